@@ design/qdv_pkg.sv @@
// Shared types and constants of the dual quadrature decoder with velocity.
package qdv_pkg;

   localparam int DT_WIDTH        = 20;
   localparam int WORD_WIDTH      = 32;
   localparam int MUL_WIDTH       = 20;
   localparam int NUM_WIDTH       = 52;   // rate numerator below the saturation limit
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [MUL_WIDTH-1:0] US_PER_S = 20'd1000000;

   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_QUERY  = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILTER_SHIFT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEADBAND     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INVERT_LEFT  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INVERT_RIGHT = 2'd3;

   typedef struct packed {
      logic sample;    // pin word accepted
      logic step_en;   // decoder primed, count may move
      logic query;     // query word accepted
   } lane_ctrl_type;

   typedef struct packed {
      logic [2:0]  filter_shift;
      logic [15:0] deadband;
      logic        invert;
   } lane_cfg_type;

   typedef struct packed {
      logic busy;
   } lane_status_type;

endpackage

@@ design/qdv_req_if.sv @@
// Request channel: pin samples and queries.
interface qdv_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic        pin_a_left;
   logic        pin_b_left;
   logic        pin_a_right;
   logic        pin_b_right;
   logic [19:0] elapsed_us;

   modport source (output valid, action, pin_a_left, pin_b_left, pin_a_right, pin_b_right,
                   elapsed_us, input ready);
   modport sink (input valid, action, pin_a_left, pin_b_left, pin_a_right, pin_b_right,
                 elapsed_us, output ready);
endinterface

@@ design/qdv_rsp_if.sv @@
// Response channel: positions and filtered velocities.
interface qdv_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] position_left;
   logic signed [31:0] position_right;
   logic signed [31:0] velocity_left;
   logic signed [31:0] velocity_right;

   modport source (output valid, position_left, position_right, velocity_left,
                   velocity_right, input ready);
   modport sink (input valid, position_left, position_right, velocity_left,
                 velocity_right, output ready);
endinterface

@@ design/qdv_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module qdv_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [qdv_pkg::NUM_WIDTH-1:0] numerator,
   input  logic [qdv_pkg::DT_WIDTH-1:0]  divisor,
   output logic [qdv_pkg::NUM_WIDTH-1:0] quotient,
   output logic                          busy
);
   localparam int CNT_WIDTH = $clog2(qdv_pkg::NUM_WIDTH + 1);

   logic [qdv_pkg::NUM_WIDTH-1:0] nq_ff, nq_in;
   logic [qdv_pkg::DT_WIDTH-1:0]  rem_ff, rem_in;
   logic [qdv_pkg::DT_WIDTH-1:0]  div_ff;
   logic [CNT_WIDTH-1:0]          cnt_ff;
   logic                          busy_ff;
   logic [qdv_pkg::DT_WIDTH:0]    trial;
   logic                          ge;

   always_comb begin
      trial  = {rem_ff, nq_ff[qdv_pkg::NUM_WIDTH-1]};
      ge     = trial >= {1'b0, div_ff};
      rem_in = ge ? qdv_pkg::DT_WIDTH'(trial - {1'b0, div_ff})
                  : trial[qdv_pkg::DT_WIDTH-1:0];
      nq_in  = {nq_ff[qdv_pkg::NUM_WIDTH-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_WIDTH'(qdv_pkg::NUM_WIDTH);
         nq_ff   <= numerator;
         rem_ff  <= '0;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         nq_ff  <= nq_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign quotient = nq_ff;
   assign busy     = busy_ff;
endmodule

@@ design/qdv_lane.sv @@
// One encoder lane: 4x decoder, rate estimate and smoothing filter.
module qdv_lane #(
   parameter int COUNT_WIDTH   = 32,
   parameter int FRACTION_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  qdv_pkg::lane_ctrl_type       ctrl,
   input  logic                         pin_a,
   input  logic                         pin_b,
   input  logic [qdv_pkg::DT_WIDTH-1:0] elapsed_us,
   input  qdv_pkg::lane_cfg_type        cfg,
   output logic [COUNT_WIDTH-1:0]       count,
   output logic signed [31:0]           velocity,
   output qdv_pkg::lane_status_type     status
);
   localparam longint unsigned SCALE   = 64'd1000000 << FRACTION_BITS;
   // smallest delta whose scaled value reaches 2^NUM_WIDTH: always saturates
   localparam longint unsigned MAG_LIM =
      ((64'd1 << qdv_pkg::NUM_WIDTH) + SCALE - 64'd1) / SCALE;
   localparam int MW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 33;
   localparam int PW = 32 + qdv_pkg::MUL_WIDTH;

   typedef enum logic [2:0] {L_IDLE, L_MUL, L_LOAD, L_DIV, L_SAT, L_FILT} lane_state_type;

   lane_state_type            state_ff;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic [COUNT_WIDTH-1:0]    prev_ff;
   logic                      last_a_ff, last_b_ff;
   logic                      neg_ff, big_ff;
   logic [31:0]               mag_ff;
   logic [qdv_pkg::DT_WIDTH-1:0] dt_ff;
   logic [PW-1:0]             prod_ff;
   logic signed [31:0]        raw_ff, raw_in;
   logic signed [31:0]        smoothed_ff, smoothed_in;
   logic signed [31:0]        vel_ff;

   // decoder
   logic chg_a, chg_b, up;
   // query capture
   logic [COUNT_WIDTH-1:0] delta, mag;
   logic [MW-1:0]          mag_ext;
   // divider
   logic                          div_start, div_busy;
   logic [qdv_pkg::NUM_WIDTH-1:0] quotient, numerator;
   logic                          over;
   // filter
   logic signed [32:0] diff, stepv, snew, smag;

   always_comb begin
      chg_a    = pin_a ^ last_a_ff;
      chg_b    = pin_b ^ last_b_ff;
      up       = (chg_a ? (pin_a ~^ pin_b) : (pin_a ^ pin_b)) ^ cfg.invert;
      count_in = count_ff;
      if (ctrl.sample && ctrl.step_en && (chg_a || chg_b)) begin
         count_in = up ? count_ff + COUNT_WIDTH'(1) : count_ff - COUNT_WIDTH'(1);
      end
   end

   always_comb begin
      delta   = count_ff - prev_ff;
      mag     = delta[COUNT_WIDTH-1] ? COUNT_WIDTH'(0) - delta : delta;
      mag_ext = MW'(mag);
   end

   assign numerator = qdv_pkg::NUM_WIDTH'(prod_ff << FRACTION_BITS);
   assign div_start = (state_ff == L_LOAD);

   always_comb begin
      if (neg_ff) begin
         over   = big_ff || (quotient > qdv_pkg::NUM_WIDTH'(33'h0_8000_0000));
         raw_in = over ? 32'sh8000_0000 : -$signed(quotient[31:0]);
      end else begin
         over   = big_ff || (quotient > qdv_pkg::NUM_WIDTH'(32'h7FFF_FFFF));
         raw_in = over ? 32'sh7FFF_FFFF : $signed(quotient[31:0]);
      end
   end

   // smoothed += floor((raw - smoothed) / 2^shift), then deadband
   always_comb begin
      diff  = 33'(raw_ff) - 33'(smoothed_ff);
      stepv = diff >>> cfg.filter_shift;
      snew  = 33'(smoothed_ff) + stepv;
      smag  = snew[32] ? -snew : snew;
      smoothed_in = ($unsigned(smag) < 33'(cfg.deadband)) ? 32'sd0 : snew[31:0];
   end

   qdv_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numerator(numerator),
      .divisor  (dt_ff),
      .quotient (quotient),
      .busy     (div_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= L_IDLE;
         count_ff    <= '0;
         prev_ff     <= '0;
         last_a_ff   <= 1'b0;
         last_b_ff   <= 1'b0;
         smoothed_ff <= '0;
         vel_ff      <= '0;
      end else begin
         count_ff <= count_in;
         if (ctrl.sample) begin
            last_a_ff <= pin_a;
            last_b_ff <= pin_b;
         end
         unique case (state_ff)
            L_IDLE: begin
               if (ctrl.query) begin
                  prev_ff <= count_ff;
                  neg_ff  <= delta[COUNT_WIDTH-1];
                  big_ff  <= mag_ext >= MW'(MAG_LIM);
                  mag_ff  <= mag_ext[31:0];
                  // the request bus moves on, keep the divisor here
                  dt_ff   <= elapsed_us;
                  if (elapsed_us == '0) begin
                     vel_ff <= '0;
                  end else begin
                     state_ff <= L_MUL;
                  end
               end
            end
            L_MUL: begin
               prod_ff  <= PW'(mag_ff) * PW'(qdv_pkg::US_PER_S);
               state_ff <= L_LOAD;
            end
            L_LOAD: begin
               state_ff <= L_DIV;
            end
            L_DIV: begin
               if (!div_busy) begin
                  state_ff <= L_SAT;
               end
            end
            L_SAT: begin
               raw_ff   <= raw_in;
               state_ff <= L_FILT;
            end
            L_FILT: begin
               smoothed_ff <= smoothed_in;
               vel_ff      <= smoothed_in;
               state_ff    <= L_IDLE;
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign count       = count_ff;
   assign velocity    = vel_ff;
   assign status.busy = (state_ff != L_IDLE);
endmodule

@@ design/dual_quadrature_decoder_velocity.sv @@
// Top level: two encoder lanes, configuration registers and response merge.
//
// Decodes two quadrature encoders (left, right) at 4x resolution. A sample
// word (action 0) carries the four pin levels and is taken every cycle while
// no query is in flight; the first sample after reset only records levels.
// A query word (action 1) returns both positions (low 32 bits of the
// wrapping counts) and the filtered velocities in Q24.8 ticks/s. A query
// with nonzero elapsed time runs capture, a 32x20 multiply, a start state,
// a 52-step restoring divider (one quotient bit per cycle, one divider per
// lane, plus a wait state to see it finish), a saturation step, a filter step
// and the load of the response register; both lanes run in lockstep. A query
// with zero elapsed time skips the rate path and returns zero velocity.
// Samples and queries stall while a query is in flight, and a finished query
// also waits while the previous response has not been taken. The response
// sits in an output register, so sample words keep flowing while it waits to
// be taken. The user must write configuration through the csr_ port only
// while idle; the block itself does not enforce it.
module dual_quadrature_decoder_velocity #(
   parameter int COUNT_WIDTH   = 32,
   parameter int FRACTION_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   qdv_req_if.sink                              req_ch,
   qdv_rsp_if.source                            rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [qdv_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [qdv_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   typedef enum logic {T_IDLE, T_RUN} top_state_type;

   top_state_type state_ff;

   // configuration
   logic [2:0]  filter_shift_ff;
   logic [15:0] deadband_ff;
   logic        invert_left_ff, invert_right_ff;

   logic primed_ff;

   // response register
   logic               rsp_valid_ff;
   logic signed [31:0] pos_left_ff, pos_right_ff;
   logic signed [31:0] out_pos_left_ff, out_pos_right_ff;
   logic signed [31:0] out_vel_left_ff, out_vel_right_ff;

   logic                      req_fire, rsp_fire, query_fire, sample_fire;
   logic                      lanes_done, load_rsp;
   qdv_pkg::lane_ctrl_type    lane_ctrl;
   qdv_pkg::lane_cfg_type     cfg_left, cfg_right;
   qdv_pkg::lane_status_type  status_left, status_right;
   logic [COUNT_WIDTH-1:0]    count_left, count_right;
   logic signed [31:0]        vel_left, vel_right;

   assign req_ch.ready = (state_ff == T_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign sample_fire  = req_fire && (req_ch.action == qdv_pkg::ACTION_SAMPLE);
   assign query_fire   = req_fire && (req_ch.action == qdv_pkg::ACTION_QUERY);
   assign rsp_fire     = rsp_valid_ff && rsp_ch.ready;

   // lanes finish together; result moves out once the output slot frees
   assign lanes_done = !status_left.busy && !status_right.busy;
   assign load_rsp   = (state_ff == T_RUN) && lanes_done && (!rsp_valid_ff || rsp_ch.ready);

   assign lane_ctrl.sample  = sample_fire;
   assign lane_ctrl.step_en = primed_ff;
   assign lane_ctrl.query   = query_fire;

   assign cfg_left.filter_shift  = filter_shift_ff;
   assign cfg_left.deadband      = deadband_ff;
   assign cfg_left.invert        = invert_left_ff;
   assign cfg_right.filter_shift = filter_shift_ff;
   assign cfg_right.deadband     = deadband_ff;
   assign cfg_right.invert       = invert_right_ff;

   qdv_lane #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_lane_left (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .pin_a     (req_ch.pin_a_left),
      .pin_b     (req_ch.pin_b_left),
      .elapsed_us(req_ch.elapsed_us),
      .cfg       (cfg_left),
      .count     (count_left),
      .velocity  (vel_left),
      .status    (status_left)
   );

   qdv_lane #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_lane_right (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .pin_a     (req_ch.pin_a_right),
      .pin_b     (req_ch.pin_b_right),
      .elapsed_us(req_ch.elapsed_us),
      .cfg       (cfg_right),
      .count     (count_right),
      .velocity  (vel_right),
      .status    (status_right)
   );

   // configuration writes; reset values match the documented defaults
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_shift_ff <= 3'd1;
         deadband_ff     <= 16'd128;
         invert_left_ff  <= 1'b0;
         invert_right_ff <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            qdv_pkg::CSR_FILTER_SHIFT: filter_shift_ff <= csr_wdata[2:0];
            qdv_pkg::CSR_DEADBAND:     deadband_ff     <= csr_wdata;
            qdv_pkg::CSR_INVERT_LEFT:  invert_left_ff  <= csr_wdata[0];
            qdv_pkg::CSR_INVERT_RIGHT: invert_right_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // control sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (sample_fire) begin
            primed_ff <= 1'b1;
         end
         // a load in the cycle the old word leaves keeps the slot full
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            T_IDLE: begin
               if (query_fire) begin
                  // positions are taken at acceptance, before any later sample
                  pos_left_ff  <= 32'(count_left);
                  pos_right_ff <= 32'(count_right);
                  state_ff     <= T_RUN;
               end
            end
            T_RUN: begin
               if (load_rsp) begin
                  out_pos_left_ff  <= pos_left_ff;
                  out_pos_right_ff <= pos_right_ff;
                  out_vel_left_ff  <= vel_left;
                  out_vel_right_ff <= vel_right;
                  state_ff         <= T_IDLE;
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.position_left  = out_pos_left_ff;
   assign rsp_ch.position_right = out_pos_right_ff;
   assign rsp_ch.velocity_left  = out_vel_left_ff;
   assign rsp_ch.velocity_right = out_vel_right_ff;

   // lanes share the elapsed time and must stay in lockstep
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      status_left.busy == status_right.busy)
      else $error("lanes out of lockstep");

   // a busy lane means a query is in flight
   a_busy_run: assert property (@(posedge clock) disable iff (reset)
      status_left.busy |-> (state_ff == T_RUN))
      else $error("lane busy outside a query");

   a_query_run: assert property (@(posedge clock) disable iff (reset)
      query_fire |=> (state_ff == T_RUN))
      else $error("query accepted but not started");

   // a new response only comes out of a finished query
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == T_RUN && lanes_done))
      else $error("response without finished query");
endmodule

@@ tb/velocity_checker.sv @@
// Watches both channels, predicts each query readout and compares it field by field.
`timescale 1ns / 100ps

module velocity_checker (
   input  logic                                clock,
   input  logic                                reset,
   qdv_req_if                                  req_mon,
   qdv_rsp_if                                  rsp_mon,
   input  logic                                csr_wr_en,
   input  logic [qdv_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [qdv_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                  error_count,
   output int                                  pending,
   output int                                  samples_seen,
   output int                                  queries_seen,
   output int                                  zero_dt_seen,
   output int                                  clipped_seen
);
   localparam int FRACTION_BITS = 8;
   localparam longint unsigned RATE_SCALE = 64'd1000000 << FRACTION_BITS;
   localparam longint RATE_MAX = 64'sh7FFF_FFFF;
   localparam longint RATE_MIN = -64'sh8000_0000;

   typedef struct packed {
      logic signed [31:0] pos_l;
      logic signed [31:0] pos_r;
      logic signed [31:0] vel_l;
      logic signed [31:0] vel_r;
   } encoder_readout_type;

   // register copies
   logic [2:0]  shift_cfg;
   logic [15:0] deadband_cfg;
   logic        inv_l_cfg, inv_r_cfg;

   // decoder and filter state
   logic [31:0] count_l, count_r, prev_l, prev_r;
   logic [3:0]  pins_seen;
   logic        primed;
   longint      smooth_l, smooth_r;

   encoder_readout_type readout_q[$];

   // 4x decode: A change wins over B change
   function automatic logic [31:0] step_count(logic [31:0] cnt, logic a, logic b,
                                              logic la, logic lb, logic inv);
      int dir;
      dir = 0;
      if (a != la) begin
         dir = (a == b) ? 1 : -1;
      end else if (b != lb) begin
         dir = (a == b) ? -1 : 1;
      end
      if (inv) begin
         dir = -dir;
      end
      return cnt + 32'(dir);
   endfunction

   // count delta over elapsed time, Q24.8 ticks/s, clipped to 32 bits
   function automatic longint rate_q8(logic [31:0] cur, logic [31:0] prev, logic [19:0] dt);
      logic [31:0]     diff, mag32;
      longint unsigned mag, quot;
      diff  = cur - prev;
      mag32 = diff[31] ? (~diff + 32'd1) : diff;
      mag   = 64'(mag32);
      quot  = (mag * RATE_SCALE) / 64'(dt);
      if (diff[31]) begin
         if (quot > 64'h8000_0000) begin
            return RATE_MIN;
         end
         return -longint'(quot);
      end
      if (quot > 64'h7FFF_FFFF) begin
         return RATE_MAX;
      end
      return longint'(quot);
   endfunction

   // exponential filter with floor step, then deadband
   function automatic longint filter_step(longint s, longint raw);
      longint mag;
      s   = s + ((raw - s) >>> shift_cfg);
      mag = (s < 0) ? -s : s;
      if (mag < longint'({48'b0, deadband_cfg})) begin
         s = 0;
      end
      return s;
   endfunction

   task automatic check_field(string label, logic signed [31:0] want_v,
                              logic signed [31:0] got_v);
      if (want_v !== got_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      encoder_readout_type want, got;
      longint raw_l, raw_r;
      if (reset) begin
         shift_cfg    = 3'd1;
         deadband_cfg = 16'd128;
         inv_l_cfg    = 1'b0;
         inv_r_cfg    = 1'b1;
         count_l      = '0;
         count_r      = '0;
         prev_l       = '0;
         prev_r       = '0;
         pins_seen    = '0;
         primed       = 1'b0;
         smooth_l     = 0;
         smooth_r     = 0;
         readout_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               qdv_pkg::CSR_FILTER_SHIFT: shift_cfg = csr_wdata[2:0];
               qdv_pkg::CSR_DEADBAND:     deadband_cfg = csr_wdata;
               qdv_pkg::CSR_INVERT_LEFT:  inv_l_cfg = csr_wdata[0];
               qdv_pkg::CSR_INVERT_RIGHT: inv_r_cfg = csr_wdata[0];
               default: ;
            endcase
         end

         // response first, so a readout never matches a query of the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.position_left, rsp_mon.position_right,
                    rsp_mon.velocity_left, rsp_mon.velocity_right};
            if (readout_q.size() == 0) begin
               error_count++;
               $display("%0t: readout with none expected, actual pos %0d/%0d vel %0d/%0d",
                        $time, got.pos_l, got.pos_r, got.vel_l, got.vel_r);
            end else begin
               want = readout_q.pop_front();
               queries_seen++;
               check_field("position_left", want.pos_l, got.pos_l);
               check_field("position_right", want.pos_r, got.pos_r);
               check_field("velocity_left", want.vel_l, got.vel_l);
               check_field("velocity_right", want.vel_r, got.vel_r);
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.action == qdv_pkg::ACTION_SAMPLE) begin
               samples_seen++;
               if (primed) begin
                  count_l = step_count(count_l, req_mon.pin_a_left, req_mon.pin_b_left,
                                       pins_seen[0], pins_seen[1], inv_l_cfg);
                  count_r = step_count(count_r, req_mon.pin_a_right, req_mon.pin_b_right,
                                       pins_seen[2], pins_seen[3], inv_r_cfg);
               end
               pins_seen = {req_mon.pin_b_right, req_mon.pin_a_right,
                            req_mon.pin_b_left, req_mon.pin_a_left};
               primed = 1'b1;
            end else begin
               want.pos_l = count_l;
               want.pos_r = count_r;
               want.vel_l = '0;
               want.vel_r = '0;
               if (req_mon.elapsed_us != '0) begin
                  raw_l = rate_q8(count_l, prev_l, req_mon.elapsed_us);
                  raw_r = rate_q8(count_r, prev_r, req_mon.elapsed_us);
                  if (raw_l == RATE_MAX || raw_l == RATE_MIN ||
                      raw_r == RATE_MAX || raw_r == RATE_MIN) begin
                     clipped_seen++;
                  end
                  smooth_l   = filter_step(smooth_l, raw_l);
                  smooth_r   = filter_step(smooth_r, raw_r);
                  want.vel_l = smooth_l[31:0];
                  want.vel_r = smooth_r[31:0];
               end else begin
                  zero_dt_seen++;
               end
               prev_l = count_l;
               prev_r = count_r;
               readout_q.push_back(want);
            end
         end
      end
      pending <= readout_q.size();
   end

endmodule

@@ tb/testbench.sv @@
// Top of the encoder decoder bench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps

module testbench;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES  = 400;     // long response hold-off

   logic                                clock;
   logic                                reset;
   logic                                csr_wr_en;
   logic [qdv_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [qdv_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   // flow control knobs, percent of cycles idle
   int tx_idle_pct;
   int rx_idle_pct;
   bit hold_request;
   bit hold_done;
   int hold_left;
   int cycle_count;

   // encoder walk: current pin levels {B right, A right, B left, A left}
   logic [3:0] pins_now;
   int         dir_l, dir_r;

   int error_count, pending, samples_seen, queries_seen, zero_dt_seen, clipped_seen;

   qdv_req_if req_bus ();
   qdv_rsp_if rsp_bus ();

   dual_quadrature_decoder_velocity uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   velocity_checker velocity_chk (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .error_count  (error_count),
      .pending      (pending),
      .samples_seen (samples_seen),
      .queries_seen (queries_seen),
      .zero_dt_seen (zero_dt_seen),
      .clipped_seen (clipped_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit: anything past this is a hang.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: done, errors");
      $finish;
   end

   // Response side. Random stalls per rx_idle_pct; once asked, one long
   // hold-off so the output register stays full and the next query backs up
   // into the request channel.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Offer one word, with random sender gaps first; returns at the edge that
   // takes it. valid stays high when the next word follows with no gap.
   task automatic send_word(logic action, logic [3:0] pins, logic [19:0] elapsed);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= action;
      req_bus.pin_a_left  <= pins[0];
      req_bus.pin_b_left  <= pins[1];
      req_bus.pin_a_right <= pins[2];
      req_bus.pin_b_right <= pins[3];
      req_bus.elapsed_us  <= elapsed;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // elapsed time is a don't-care on a sample, so it carries noise
   task automatic sample_pins(logic [3:0] pins);
      pins_now = pins;
      send_word(qdv_pkg::ACTION_SAMPLE, pins, 20'($urandom));
   endtask

   // pin levels are a don't-care on a query
   task automatic query(logic [19:0] elapsed);
      send_word(qdv_pkg::ACTION_QUERY, 4'($urandom), elapsed);
   endtask

   // one legal quadrature step on a {B, A} pair; dir 0 holds
   function automatic logic [1:0] gray_move(logic [1:0] ba, int dir);
      if (dir == 0) begin
         return ba;
      end
      if ((dir > 0) == (ba[0] == ba[1])) begin
         return {ba[1], ~ba[0]};
      end
      return {~ba[1], ba[0]};
   endfunction

   task automatic walk(int step_l, int step_r);
      sample_pins({gray_move(pins_now[3:2], step_r), gray_move(pins_now[1:0], step_l)});
   endtask

   // small times push the rate into clipping, large ones reach the top bits
   function automatic logic [19:0] pick_elapsed();
      int pick;
      pick = $urandom_range(99);
      if (pick < 6) begin
         return '0;
      end else if (pick < 36) begin
         return 20'($urandom_range(40, 1));
      end else if (pick < 66) begin
         return 20'($urandom_range(5000, 41));
      end else if (pick < 96) begin
         return 20'($urandom_range(20'hFFFFF, 1));
      end
      return 20'hFFFFF;
   endfunction

   // Mostly clean encoder motion with runs and reversals, some pin noise
   // (double changes exercise A-over-B priority), and occasional queries.
   task automatic random_word();
      int pick;
      int step_l, step_r;
      pick = $urandom_range(99);
      if (pick < 12) begin
         query(pick_elapsed());
      end else if (pick < 28) begin
         sample_pins(4'($urandom));
      end else begin
         if ($urandom_range(99) < 15) dir_l = -dir_l;
         if ($urandom_range(99) < 15) dir_r = -dir_r;
         step_l = ($urandom_range(99) < 20) ? 0 : dir_l;
         step_r = ($urandom_range(99) < 20) ? 0 : dir_r;
         walk(step_l, step_r);
      end
   endtask

   // Stop offering words and let every readout come home, then allow the
   // block's own latency before touching registers or ending.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [qdv_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            logic [qdv_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic reprogram(logic [2:0] shift, logic [15:0] band, logic inv_l, logic inv_r);
      drain();
      csr_write(qdv_pkg::CSR_FILTER_SHIFT, 16'(shift));
      csr_write(qdv_pkg::CSR_DEADBAND, band);
      csr_write(qdv_pkg::CSR_INVERT_LEFT, 16'(inv_l));
      csr_write(qdv_pkg::CSR_INVERT_RIGHT, 16'(inv_r));
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(int words, int tx_pct, int rx_pct, bit long_hold);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int i = 0; i < words; i++) begin
         if (long_hold && i == words / 4) begin
            hold_request = 1'b1;
         end
         random_word();
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.action      = qdv_pkg::ACTION_SAMPLE;
      req_bus.pin_a_left  = 1'b0;
      req_bus.pin_b_left  = 1'b0;
      req_bus.pin_a_right = 1'b0;
      req_bus.pin_b_right = 1'b0;
      req_bus.elapsed_us  = '0;
      tx_idle_pct         = 0;
      rx_idle_pct         = 0;
      hold_request        = 1'b0;
      hold_done           = 1'b0;
      hold_left           = 0;
      pins_now            = '0;
      dir_l               = 1;
      dir_r               = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed pass at reset register values (right lane inverted).
      query(20'd1000);                   // query before any sample: zero counts
      sample_pins(4'b1111);              // first sample only records levels
      sample_pins(4'b0000);              // A and B both change: A wins
      repeat (10) walk(1, 1);
      query(20'd1);                      // +/- clipped rate, opposite lanes
      query(20'd0);                      // zero time: zero speed, filter kept
      repeat (8) walk(-1, 1);
      query(20'hFFFFF);                  // longest time
      query(20'd2);

      // Low extremes, sender-light / receiver-heavy stalls.
      reprogram(3'd0, 16'd0, 1'b1, 1'b0);
      run_phase(330, 31, 60, 1'b0);

      // High extremes, roles swapped.
      reprogram(3'd7, 16'hFFFF, 1'b0, 1'b1);
      run_phase(330, 60, 31, 1'b0);

      // Mid setting, free-running, with the long response hold-off.
      reprogram(3'($urandom_range(6, 1)), 16'($urandom_range(1023)),
                1'($urandom), 1'($urandom));
      run_phase(340, 0, 0, 1'b1);

      drain();

      $display("summary: %0d pin words, %0d readouts checked, %0d at zero time, %0d clipped",
               samples_seen, queries_seen, zero_dt_seen, clipped_seen);
      $display("summary: reset/min/max/mid registers, both stall mixes, one %0d-cycle hold",
               HOLD_CYCLES);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/qdv_pkg.sv
design/qdv_req_if.sv
design/qdv_rsp_if.sv
design/qdv_divider.sv
design/qdv_lane.sv
design/dual_quadrature_decoder_velocity.sv
tb/velocity_checker.sv
tb/testbench.sv
